@@ rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg - shared definitions for the fixed-point alu
// widths, operation and status codes, and the beat that runs through the
// divider cell row
// ----------------------------------------------------------------------------
package fpa_pkg;

    // number format
    localparam int FRACTION_BITS = 8;
    localparam int VALUE_BITS    = 32;

    // datapath width, at most the 32-bit field width
    localparam int W  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    // dividend width, also the number of divider cells
    localparam int NW = W + FRACTION_BITS;
    // full product width
    localparam int PW = 2 * W;
    // product rounding width, wide enough for magnitude plus rounding constant
    localparam int MW = (PW > FRACTION_BITS) ? PW + 1 : FRACTION_BITS + 2;

    // stream payload sizes
    localparam int IN_BITS   = 4 + 32 + 32;
    localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 32 + 1 + 2;
    localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

    // range limits of the datapath
    localparam logic [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

    // operation codes
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_EQ  = 4'd4;
    localparam logic [3:0] OP_NE  = 4'd5;
    localparam logic [3:0] OP_GT  = 4'd6;
    localparam logic [3:0] OP_LT  = 4'd7;
    localparam logic [3:0] OP_LE  = 4'd8;
    localparam logic [3:0] OP_GE  = 4'd9;
    localparam logic [3:0] OP_INC = 4'd10;
    localparam logic [3:0] OP_DEC = 4'd11;
    localparam logic [3:0] OP_MIN = 4'd12;
    localparam logic [3:0] OP_MAX = 4'd13;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    // result carried alongside the division, plus divide control
    typedef struct packed {
        logic [W-1:0] value;
        logic         flag;
        logic [1:0]   status;
        logic         is_div;
        logic         neg;
        logic         dz;
    } t_side;

    // one beat between divider cells
    typedef struct packed {
        logic          valid;
        logic [W-1:0]  rem;
        logic [NW-1:0] qn;
        logic [W-1:0]  den;
        t_side         side;
    } t_div_beat;

endpackage

@@ rtl/fpa_front.sv @@
// ----------------------------------------------------------------------------
// fpa_front - operand decode, simple operations and multiplier
// three registered stages: operate and multiply, product magnitude,
// product rounding with saturation and dividend set-up
// ----------------------------------------------------------------------------
module fpa_front
    import fpa_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [3:0]      i_op,
    input  logic [31:0]     i_a,
    input  logic [31:0]     i_b,
    output t_div_beat       o_beat
);

    // saturate a one-bit-wider sum into the datapath range, overflow on top
    function automatic logic [W:0] sat_w(input logic signed [W:0] s);
        logic [W:0] res;
        if (s[W] != s[W-1]) begin
            res = {1'b1, (s[W] ? W_MIN : W_MAX)};
        end else begin
            res = {1'b0, s[W-1:0]};
        end
        return res;
    endfunction

    logic signed [W-1:0]  a;
    logic signed [W-1:0]  b;
    logic [W-1:0]         a_u;
    logic [W-1:0]         b_u;
    logic [W:0]           sat_res;
    t_side                n_s0_side;
    logic signed [PW-1:0] n_s0_prod;
    logic [W-1:0]         n_s0_mag_a;
    logic [W-1:0]         n_s0_mag_b;

    logic                 r_s0_valid;
    t_side                r_s0_side;
    logic                 r_s0_is_mul;
    logic signed [PW-1:0] r_s0_prod;
    logic [W-1:0]         r_s0_mag_a;
    logic [W-1:0]         r_s0_mag_b;

    logic                 r_s1_valid;
    t_side                r_s1_side;
    logic                 r_s1_is_mul;
    logic                 r_s1_pneg;
    logic [PW-1:0]        r_s1_pmag;
    logic [W-1:0]         r_s1_mag_a;
    logic [W-1:0]         r_s1_mag_b;

    localparam logic [MW-1:0] RND = (MW'(1) << FRACTION_BITS) >> 1;

    logic [MW-1:0]        p_sum;
    logic [MW-1:0]        p_shift;
    logic                 p_over;
    t_side                n_s2_side;

    logic                 r_s2_valid;
    t_div_beat            r_s2_beat;

    // operands are the low datapath bits of each field
    assign a_u = i_a[W-1:0];
    assign b_u = i_b[W-1:0];
    assign a   = a_u;
    assign b   = b_u;

    // simple operations
    always_comb begin
        n_s0_side = '0;
        sat_res   = '0;
        case (i_op)
            OP_ADD: begin
                sat_res = sat_w((W+1)'(a) + (W+1)'(b));
            end
            OP_SUB: begin
                sat_res = sat_w((W+1)'(a) - (W+1)'(b));
            end
            OP_INC: begin
                sat_res = sat_w((W+1)'(a) + (W+1)'(1));
            end
            OP_DEC: begin
                sat_res = sat_w((W+1)'(a) - (W+1)'(1));
            end
            default: begin
                sat_res = '0;
            end
        endcase
        case (i_op)
            OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                n_s0_side.value  = sat_res[W-1:0];
                n_s0_side.status = sat_res[W] ? ST_OVF : ST_OK;
            end
            OP_DIV: begin
                n_s0_side.is_div = 1'b1;
                n_s0_side.neg    = a[W-1] ^ b[W-1];
                n_s0_side.dz     = (b_u == '0);
                n_s0_side.status = (b_u == '0) ? ST_DIVZ : ST_OK;
            end
            OP_EQ:   n_s0_side.flag  = (a == b);
            OP_NE:   n_s0_side.flag  = (a != b);
            OP_GT:   n_s0_side.flag  = (a > b);
            OP_LT:   n_s0_side.flag  = (a < b);
            OP_LE:   n_s0_side.flag  = (a <= b);
            OP_GE:   n_s0_side.flag  = (a >= b);
            OP_MIN:  n_s0_side.value = (a < b) ? a_u : b_u;
            OP_MAX:  n_s0_side.value = (a > b) ? a_u : b_u;
            default: n_s0_side       = '0;
        endcase
    end

    // full product and operand magnitudes
    assign n_s0_prod  = PW'(a) * PW'(b);
    assign n_s0_mag_a = a[W-1] ? (~a_u + 1'b1) : a_u;
    assign n_s0_mag_b = b[W-1] ? (~b_u + 1'b1) : b_u;

    // stage 0 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (i_en) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_side   <= n_s0_side;
            r_s0_is_mul <= (i_op == OP_MUL);
            r_s0_prod   <= n_s0_prod;
            r_s0_mag_a  <= n_s0_mag_a;
            r_s0_mag_b  <= n_s0_mag_b;
        end
    end

    // stage 1: product magnitude and sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_side   <= r_s0_side;
            r_s1_is_mul <= r_s0_is_mul;
            r_s1_pneg   <= r_s0_prod[PW-1];
            r_s1_pmag   <= r_s0_prod[PW-1] ? (~r_s0_prod + 1'b1) : r_s0_prod;
            r_s1_mag_a  <= r_s0_mag_a;
            r_s1_mag_b  <= r_s0_mag_b;
        end
    end

    // product rounding half away from zero, then saturation
    assign p_sum   = MW'(r_s1_pmag) + RND;
    assign p_shift = p_sum >> FRACTION_BITS;
    assign p_over  = r_s1_pneg ? (p_shift > MW'(W_MIN)) : (p_shift > MW'(W_MAX));

    always_comb begin
        n_s2_side = r_s1_side;
        if (r_s1_is_mul) begin
            if (p_over) begin
                n_s2_side.value  = r_s1_pneg ? W_MIN : W_MAX;
                n_s2_side.status = ST_OVF;
            end else begin
                n_s2_side.value  = r_s1_pneg ? (~p_shift[W-1:0] + 1'b1) : p_shift[W-1:0];
                n_s2_side.status = ST_OK;
            end
        end
    end

    // stage 2: beat into the divider row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_beat.valid <= 1'b0;
            r_s2_beat.rem   <= '0;
            r_s2_beat.qn    <= NW'(r_s1_mag_a) << FRACTION_BITS;
            r_s2_beat.den   <= r_s1_mag_b;
            r_s2_beat.side  <= n_s2_side;
        end
    end

    always_comb begin
        o_beat       = r_s2_beat;
        o_beat.valid = r_s2_valid;
    end

endmodule

@@ rtl/fpa_div_cell.sv @@
// ----------------------------------------------------------------------------
// fpa_div_cell - one restoring division step
// takes the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit in
// ----------------------------------------------------------------------------
module fpa_div_cell
    import fpa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_div_beat i_beat,
    output t_div_beat o_beat
);

    logic [W:0]  trial;
    logic [W:0]  diff;
    logic        take;
    t_div_beat   n_beat;

    logic        r_valid;
    t_div_beat   r_beat;

    // trial subtraction
    assign trial = {i_beat.rem, i_beat.qn[NW-1]};
    assign diff  = trial - {1'b0, i_beat.den};
    assign take  = (trial >= {1'b0, i_beat.den});

    always_comb begin
        n_beat       = i_beat;
        n_beat.rem   = take ? diff[W-1:0] : trial[W-1:0];
        n_beat.qn    = {i_beat.qn[NW-2:0], take};
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_beat.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    always_comb begin
        o_beat       = r_beat;
        o_beat.valid = r_valid;
    end

endmodule

@@ rtl/fpa_out.sv @@
// ----------------------------------------------------------------------------
// fpa_out - quotient rounding and result output
// rounds the quotient half away from zero, saturates, picks the result
// and holds it in an output register with a skid stage behind it
// ----------------------------------------------------------------------------
module fpa_out
    import fpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_beat            i_beat,
    input  logic                 i_m_tready,
    output logic                 o_en,
    output logic                 o_m_tvalid,
    output logic [OUT_TDATA-1:0] o_m_tdata
);

    logic                 up;
    logic [NW:0]          q_rnd;
    logic                 q_over;
    logic [W-1:0]         q_val;
    logic [W-1:0]         res_val;
    logic signed [W-1:0]  res_s;
    logic [1:0]           res_st;
    logic [OUT_TDATA-1:0] n_data;

    logic                 r_out_valid;
    logic [OUT_TDATA-1:0] r_out_data;
    logic                 r_skid_valid;
    logic [OUT_TDATA-1:0] r_skid_data;

    // round the quotient from the final remainder
    assign up     = ({i_beat.rem, 1'b0} >= {1'b0, i_beat.den});
    assign q_rnd  = (NW+1)'(i_beat.qn) + (NW+1)'(up);
    assign q_over = i_beat.side.neg ? (q_rnd > (NW+1)'(W_MIN)) : (q_rnd > (NW+1)'(W_MAX));
    assign q_val  = i_beat.side.neg ? (~q_rnd[W-1:0] + 1'b1) : q_rnd[W-1:0];

    // result selection
    always_comb begin
        res_val = i_beat.side.value;
        res_st  = i_beat.side.status;
        if (i_beat.side.is_div) begin
            if (i_beat.side.dz) begin
                res_val = '0;
                res_st  = ST_DIVZ;
            end else if (q_over) begin
                res_val = i_beat.side.neg ? W_MIN : W_MAX;
                res_st  = ST_OVF;
            end else begin
                res_val = q_val;
                res_st  = ST_OK;
            end
        end
    end

    // pack value, flag and status from the lowest bit up
    assign res_s  = res_val;
    assign n_data = OUT_TDATA'({res_st, i_beat.side.flag, 32'(res_s)});

    // output register and skid stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_beat.valid) begin
            if (!r_out_valid || i_m_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output and skid data
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_m_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_beat.valid) begin
            if (!r_out_valid || i_m_tready) begin
                r_out_data <= n_data;
            end else begin
                r_skid_data <= n_data;
            end
        end
    end

    assign o_en       = !r_skid_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

@@ rtl/fixed_point_alu_core.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu_core - signed fixed-point alu, q24.8 raw values
// add, subtract, multiply, divide, comparisons, increment, decrement,
// minimum and maximum with rounding and saturation
// ----------------------------------------------------------------------------
// usage
//   one operation beat in on the slave side, one result beat out on the
//   master side, in the same order
//   slave tdata, lowest bit up: op[3:0], operand_a[35:4], operand_b[67:36]
//   master tdata, lowest bit up: value[31:0], flag[32], status[34:33]
//   a beat is taken at a rising edge with tvalid and tready both high
//   throughput: one beat per cycle for every operation mix while the master
//   side keeps tready high; every beat passes the front stages, the row
//   of restoring divider cells, one quotient bit per cell, and the output register;
//   every operation runs down the same row so results keep their order
//   multiplies use one 32 by 32 multiplier ahead of the row
//   stall: when the receiver holds tready low the result sits in the
//   output register and one more result drops into the skid stage; only
//   then does the whole pipeline freeze and slave tready fall
//   reset: synchronous active low i_rst_n empties all stages; no other
//   state is kept, no configuration exists
// ----------------------------------------------------------------------------
module fixed_point_alu_core
    import fpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave side: op, operand_a, operand_b
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_TDATA-1:0]  i_s_tdata,
    // master side: value, flag, status
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_TDATA-1:0] o_m_tdata
);

    logic      w_en;
    t_div_beat w_chain [NW+1];

    // decode, simple operations and multiplier
    fpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_op    (i_s_tdata[3:0]),
        .i_a     (i_s_tdata[35:4]),
        .i_b     (i_s_tdata[67:36]),
        .o_beat  (w_chain[0])
    );

    // row of divider cells, one quotient bit each
    for (genvar g = 0; g < NW; g++) begin : g_cell
        fpa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_beat  (w_chain[g]),
            .o_beat  (w_chain[g+1])
        );
    end

    // rounding, saturation and output buffering
    fpa_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_beat     (w_chain[NW]),
        .i_m_tready (i_m_tready),
        .o_en       (w_en),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

    assign o_s_tready = w_en;

endmodule
